>>> rtl/acfp_pkg.sv
// Shared types and command codes for the ASCII command frame parser.
package acfp_pkg;

	typedef logic [2:0]  cmd_t;
	typedef logic [15:0] val_t;
	typedef logic [7:0]  char_t;

	localparam cmd_t CMD_GO     = 3'd0;
	localparam cmd_t CMD_END    = 3'd1;
	localparam cmd_t CMD_SPEED  = 3'd2;
	localparam cmd_t CMD_ALT    = 3'd3;
	localparam cmd_t CMD_MANUAL = 3'd4;
	localparam cmd_t CMD_LED    = 3'd5;

	// Decoded outcome of the byte currently at the head of the parser.
	typedef struct packed {
		logic emit;
		cmd_t command;
		val_t value;
	} result_t;

endpackage

>>> rtl/acfp_in_if.sv
// Valid/ready channel that carries one received character.
interface acfp_in_if;
	logic                valid;
	logic                ready;
	acfp_pkg::char_t     rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

>>> rtl/acfp_out_if.sv
// Valid/ready channel that carries one decoded command and its value.
interface acfp_out_if;
	logic                valid;
	logic                ready;
	acfp_pkg::cmd_t      command;
	acfp_pkg::val_t      value;

	modport source(output valid, output command, output value, input ready);
	modport sink(input valid, input command, input value, output ready);
endinterface

>>> rtl/acfp_in_reg.sv
// Input register stage that captures one received character.
module acfp_in_reg (
	input  logic            clk,
	input  logic            arst_n,
	acfp_in_if.sink         rx,
	input  logic            take,
	output logic            valid_s1,
	output acfp_pkg::char_t rx_byte_s1
);
	import acfp_pkg::*;

	// The stage refills whenever it is empty or its byte moves on this cycle.
	assign rx.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			rx_byte_s1 <= rx.rx_byte;
		end
	end

endmodule

>>> rtl/acfp_parser.sv
// Frame state machine: name matching, hex accumulation and result decode.
module acfp_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  acfp_pkg::char_t   rx_byte,
	output acfp_pkg::result_t result
);
	import acfp_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_NAME = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] nib;
	} hex_t;

	typedef struct packed {
		logic       ok;
		cmd_t       kind;
		logic [2:0] digits;
	} name_t;

	localparam char_t CH_DOLLAR = 8'h24;
	localparam char_t CH_HASH   = 8'h23;
	localparam char_t CH_ZERO   = 8'h30;
	localparam char_t CH_NINE   = 8'h39;
	localparam char_t CH_UA     = 8'h41;
	localparam char_t CH_UF     = 8'h46;
	localparam char_t CH_LA     = 8'h61;
	localparam char_t CH_LF     = 8'h66;
	localparam char_t CH_A      = 8'h41;
	localparam char_t CH_D      = 8'h44;
	localparam char_t CH_E      = 8'h45;
	localparam char_t CH_G      = 8'h47;
	localparam char_t CH_L      = 8'h4C;
	localparam char_t CH_M      = 8'h4D;
	localparam char_t CH_N      = 8'h4E;
	localparam char_t CH_O      = 8'h4F;
	localparam char_t CH_P      = 8'h50;
	localparam char_t CH_S      = 8'h53;
	localparam char_t CH_T      = 8'h54;

	function automatic hex_t hex_decode(input char_t c);
		hex_t h;
		h.ok  = 1'b1;
		h.nib = 4'd0;
		if (c inside {[CH_ZERO:CH_NINE]}) begin
			h.nib = 4'(c - CH_ZERO);
		end else if (c inside {[CH_LA:CH_LF]}) begin
			h.nib = 4'(c - CH_LA + 8'd10);
		end else if (c inside {[CH_UA:CH_UF]}) begin
			h.nib = 4'(c - CH_UA + 8'd10);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

	function automatic name_t name_lookup(input char_t l0, input char_t l1, input char_t l2);
		name_t n;
		logic [23:0] w;
		w = {l0, l1, l2};
		n.ok     = 1'b1;
		n.kind   = CMD_GO;
		n.digits = 3'd0;
		if (w == {CH_G, CH_O, CH_O}) begin
			n.kind = CMD_GO;     n.digits = 3'd4;
		end else if (w == {CH_E, CH_N, CH_D}) begin
			n.kind = CMD_END;    n.digits = 3'd0;
		end else if (w == {CH_S, CH_P, CH_D}) begin
			n.kind = CMD_SPEED;  n.digits = 3'd4;
		end else if (w == {CH_A, CH_L, CH_T}) begin
			n.kind = CMD_ALT;    n.digits = 3'd4;
		end else if (w == {CH_M, CH_A, CH_N}) begin
			n.kind = CMD_MANUAL; n.digits = 3'd2;
		end else if (w == {CH_L, CH_E, CH_D}) begin
			n.kind = CMD_LED;    n.digits = 3'd2;
		end else begin
			n.ok = 1'b0;
		end
		return n;
	endfunction

	phase_t     phase_q;
	logic [1:0] pos_q;
	char_t      letters_q [2];
	cmd_t       kind_q;
	logic [2:0] expected_q;
	logic [2:0] seen_q;
	val_t       acc_q;

	hex_t  hx;
	name_t nm;
	logic  seen_match;

	assign hx         = hex_decode(rx_byte);
	assign nm         = name_lookup(letters_q[0], letters_q[1], rx_byte);
	assign seen_match = (seen_q == expected_q);

	// A frame completes on '#' in the body after exactly the expected digits.
	always_comb begin
		result.emit    = (phase_q == PH_BODY) && !hx.ok && (rx_byte == CH_HASH) && seen_match;
		result.command = kind_q;
		case (kind_q)
			CMD_END:            result.value = '0;
			CMD_MANUAL, CMD_LED: result.value = {8'h00, acc_q[7:0]};
			default:            result.value = acc_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (step && (phase_q == PH_NAME) && !pos_q[1]) begin
			letters_q[pos_q[0]] <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			pos_q      <= 2'd0;
			kind_q     <= CMD_GO;
			expected_q <= 3'd0;
			seen_q     <= 3'd0;
			acc_q      <= '0;
		end else if (step) begin
			case (phase_q)
				PH_NAME: begin
					if (!pos_q[1]) begin
						pos_q <= pos_q + 2'd1;
					end else begin
						pos_q <= 2'd0;
						if (nm.ok) begin
							kind_q     <= nm.kind;
							expected_q <= nm.digits;
							seen_q     <= 3'd0;
							phase_q    <= PH_BODY;
						end else begin
							phase_q <= PH_IDLE;
						end
					end
				end
				PH_BODY: begin
					if (hx.ok) begin
						if (seen_match) begin
							phase_q <= PH_IDLE;
						end else begin
							acc_q  <= {acc_q[11:0], hx.nib};
							seen_q <= seen_q + 3'd1;
						end
					end else if (rx_byte != CH_HASH) begin
						phase_q <= PH_IDLE;
					end else begin
						seen_q  <= 3'd0;
						acc_q   <= '0;
						phase_q <= PH_IDLE;
					end
				end
				default: begin
					phase_q <= (rx_byte == CH_DOLLAR) ? PH_NAME : PH_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/acfp_out_reg.sv
// Output register that holds one decoded command until it is taken.
module acfp_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  acfp_pkg::result_t result,
	input  logic              step,
	output logic              free,
	acfp_out_if.source        res
);
	import acfp_pkg::*;

	logic valid_q;
	cmd_t command_q;
	val_t value_q;
	logic load;

	assign load      = step && result.emit;
	assign free      = !valid_q || res.ready;
	assign res.valid   = valid_q;
	assign res.command = command_q;
	assign res.value   = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			command_q <= result.command;
			value_q   <= result.value;
		end
	end

endmodule

>>> rtl/ascii_command_frame_parser_core.sv
// Top level of the ASCII command frame parser.
//
//   Channel  Role   Payload                     Transaction
//   rx       sink   rx_byte[7:0]                one received character
//   res      source command[2:0], value[15:0]  one complete command frame
//
// One character is taken every cycle unless a completing '#' is stalled.
// A character is captured in the input register, then decoded by the frame
// state machine in the following cycle; a completed frame is loaded into the
// output register at the end of the cycle in which the output register is
// free, and res.valid is driven straight from the output register.
// Reset clears the frame state to idle and empties both registers.
// While a result waits on res, characters that complete no frame keep
// flowing; only a terminating '#' waits for the output register to free up.

module ascii_command_frame_parser_core (
	input  logic   clk,
	input  logic   arst_n,
	acfp_in_if.sink   rx,
	acfp_out_if.source res
);
	import acfp_pkg::*;

	logic    valid_s1;
	char_t   rx_byte_s1;
	result_t result;
	logic    free;
	logic    step;

	// The captured character is consumed when it produces no result, or when
	// the output register can take the result it produces.
	assign step = valid_s1 && (!result.emit || free);

	acfp_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.take       (step),
		.valid_s1   (valid_s1),
		.rx_byte_s1 (rx_byte_s1)
	);

	// The parser advances its frame state only when the character moves on,
	// so a stalled '#' is decoded again with identical state next cycle.
	acfp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (rx_byte_s1),
		.result  (result)
	);

	acfp_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.result (result),
		.step   (step),
		.free   (free),
		.res    (res)
	);

endmodule

>>> rtl/acfp_checker.sv
// Port-level checks on the frame parser results, bound to the top level.
module acfp_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           res_valid,
	input logic           res_ready,
	input acfp_pkg::cmd_t res_command,
	input acfp_pkg::val_t res_value
);
	import acfp_pkg::*;

	a_cmd_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_command <= CMD_LED))
		else $error("command code out of range");

	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res_command == CMD_END)) |-> (res_value == 16'd0))
		else $error("end command carries a nonzero value");

	a_byte_value: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && ((res_command == CMD_MANUAL) || (res_command == CMD_LED)))
		|-> (res_value[15:8] == 8'd0))
		else $error("two-digit command has high value bits set");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready)
		|=> (res_valid && $stable(res_command) && $stable(res_value)))
		else $error("stalled result changed or dropped");

endmodule

bind ascii_command_frame_parser_core acfp_checker u_acfp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.res_command (res.command),
	.res_value   (res.value)
);
